/* design/smss_pkg.sv */
// ----------------------------------------------------------------------------
// smss_pkg: shared types and constants for the segmented MaxSim scorer
// Field widths, the accumulator's saturation limits and the control struct
// that the top level hands to the maximum table and the sum unit.
// ----------------------------------------------------------------------------
package smss_pkg;

    localparam int SCORE_W           = 16;
    localparam int QIDX_W            = 5;
    localparam int SUM_W             = 21;
    localparam int CFG_W             = 6;
    localparam int QUERY_VECTORS_DEF = 32;
    localparam int ACTIVE_RESET      = 32;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Per-cycle control from the top level's input stage.
    typedef struct packed {
        logic fire;           // an in-range item is processed this cycle
        logic last_vector;    // the item belongs to the document's last vector
        logic end_of_vector;  // the item carries the last active query index
    } t_step_ctl;

endpackage

/* design/smss_in_if.sv */
// ----------------------------------------------------------------------------
// smss_in_if: score item channel
// Valid/ready channel that carries one similarity score and its position.
// ----------------------------------------------------------------------------
interface smss_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [smss_pkg::SCORE_W-1:0]   score;
    logic        [smss_pkg::QIDX_W-1:0]    query_index;
    logic                                  last_vector;

    modport source (output valid, output score, output query_index,
                    output last_vector, input ready);
    modport sink   (input valid, input score, input query_index,
                    input last_vector, output ready);
endinterface

/* design/smss_out_if.sv */
// ----------------------------------------------------------------------------
// smss_out_if: document score channel
// Valid/ready channel that carries one finished document score.
// ----------------------------------------------------------------------------
interface smss_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [smss_pkg::SUM_W-1:0]   doc_score;

    modport source (output valid, output doc_score, input ready);
    modport sink   (input valid, input doc_score, output ready);
endinterface

/* design/smss_max_table.sv */
// ----------------------------------------------------------------------------
// smss_max_table: per-query running maximum
// Holds one running maximum per query index and updates the addressed entry
// when an item is processed; the new maximum is also driven out.
// ----------------------------------------------------------------------------
module smss_max_table #(
    parameter int DEPTH = smss_pkg::QUERY_VECTORS_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  smss_pkg::t_step_ctl                  i_ctl,
    input  logic [IDX_W-1:0]                     i_index,
    input  logic signed [smss_pkg::SCORE_W-1:0]  i_score,
    input  logic                                 i_doc_start,
    output logic signed [smss_pkg::SCORE_W-1:0]  o_max
);

    logic signed [smss_pkg::SCORE_W-1:0] r_max [DEPTH];
    logic signed [smss_pkg::SCORE_W-1:0] w_old;

    assign w_old = r_max[i_index];

    // The first vector of a document starts the maximum over from the score.
    assign o_max = (i_doc_start || (i_score > w_old)) ? i_score : w_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_max[k] <= '0;
            end
        end else if (i_ctl.fire) begin
            r_max[i_index] <= o_max;
        end
    end

endmodule

/* design/smss_sum_unit.sv */
// ----------------------------------------------------------------------------
// smss_sum_unit: saturating document sum and result register
// Adds final maxima on a document's last vector and presents the document
// score in an output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module smss_sum_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  smss_pkg::t_step_ctl                  i_ctl,
    input  logic signed [smss_pkg::SCORE_W-1:0]  i_max,
    output logic                                 o_hold,
    smss_out_if.source                           o_result
);

    localparam int WIDE_W = smss_pkg::SUM_W + 1;

    logic signed [smss_pkg::SUM_W-1:0] r_sum;
    logic signed [smss_pkg::SUM_W-1:0] n_sum;
    logic signed [smss_pkg::SUM_W-1:0] r_doc_score;
    logic                              r_out_valid;
    logic signed [WIDE_W-1:0]          w_wide;
    logic signed [smss_pkg::SUM_W-1:0] w_total;
    logic                              w_emit;

    assign w_wide = WIDE_W'(r_sum) + WIDE_W'(i_max);

    always_comb begin
        priority if (w_wide > WIDE_W'(smss_pkg::SUM_MAX)) begin
            w_total = smss_pkg::SUM_MAX;
        end else if (w_wide < WIDE_W'(smss_pkg::SUM_MIN)) begin
            w_total = smss_pkg::SUM_MIN;
        end else begin
            w_total = w_wide[smss_pkg::SUM_W-1:0];
        end
    end

    assign w_emit = i_ctl.fire && i_ctl.last_vector && i_ctl.end_of_vector;

    always_comb begin
        n_sum = r_sum;
        if (i_ctl.fire && i_ctl.last_vector) begin
            n_sum = i_ctl.end_of_vector ? '0 : w_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum <= n_sum;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_doc_score <= w_total;
        end
    end

    assign o_hold             = r_out_valid && !o_result.ready;
    assign o_result.valid     = r_out_valid;
    assign o_result.doc_score = r_doc_score;

    // A finished document always shows up in the result register.
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_out_valid)
        else $error("document end did not load the result register");

    // The accumulator starts the next document from zero.
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_sum == '0))
        else $error("accumulator not cleared after a document");

    // No item is processed while a result waits on a stalled output.
    a_no_fire_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hold |-> !i_ctl.fire)
        else $error("item processed while the result register is stalled");

endmodule

/* design/segmented_maxsim_score.sv */
// ----------------------------------------------------------------------------
// segmented_maxsim_score: late-interaction document scorer
// Keeps a running maximum per query index over each document and emits the
// saturated sum of those maxima after the last query of the last vector.
// ----------------------------------------------------------------------------
// Flow: the score item that ends a document waits in the input register,
//   then its document score is loaded into the result register.
// Throughput: one score item per cycle while the output is not stalled; the
//   input and result registers let a transfer happen while a score waits.
// Reset (synchronous, active low): active query count 32, all maxima zero,
//   accumulator zero, next vector treated as a document's first.
// ----------------------------------------------------------------------------
module segmented_maxsim_score #(
    parameter int QUERY_VECTORS = smss_pkg::QUERY_VECTORS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [smss_pkg::CFG_W-1:0]      i_cfg_wdata,
    smss_in_if.sink                         i_item,
    smss_out_if.source                      o_result
);

    // Only query indices that fit the 5-bit field can ever be addressed, so
    // the table is as deep as the smaller of the parameter and that range.
    localparam int IDX_SPAN = 2 ** smss_pkg::QIDX_W;
    localparam int LIM      = (QUERY_VECTORS < IDX_SPAN) ? QUERY_VECTORS : IDX_SPAN;
    localparam int IDX_W    = (LIM > 1) ? $clog2(LIM) : 1;

    // The configuration register is kept as the last active query index,
    // already clamped to 1 .. LIM queries, so the datapath only compares.
    localparam int RESET_CNT = (smss_pkg::ACTIVE_RESET < LIM) ?
                               smss_pkg::ACTIVE_RESET : LIM;

    logic [smss_pkg::QIDX_W-1:0]           r_last_idx;
    logic [smss_pkg::QIDX_W-1:0]           n_last_idx;

    // Input register: one accepted score item waiting to be processed.
    logic                                  r_in_valid;
    logic signed [smss_pkg::SCORE_W-1:0]   r_score;
    logic [smss_pkg::QIDX_W-1:0]           r_query_index;
    logic                                  r_last_vector;

    // Set while the first vector of a document is streaming.
    logic                                  r_doc_start;

    logic                                  w_hold;
    logic                                  w_advance;
    logic                                  w_in_range;
    logic signed [smss_pkg::SCORE_W-1:0]   w_max;
    smss_pkg::t_step_ctl                   w_ctl;

    // Configuration clamp: zero acts as one query, values above the table
    // depth act as the full table.
    always_comb begin
        priority if (i_cfg_wdata == '0) begin
            n_last_idx = '0;
        end else if (i_cfg_wdata > smss_pkg::CFG_W'(LIM)) begin
            n_last_idx = smss_pkg::QIDX_W'(LIM - 1);
        end else begin
            n_last_idx = smss_pkg::QIDX_W'(i_cfg_wdata - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= smss_pkg::QIDX_W'(RESET_CNT - 1);
        end else if (i_cfg_we) begin
            r_last_idx <= n_last_idx;
        end
    end

    // The input register moves on whenever the result register can take a
    // new score, i.e. it is empty or being drained in this cycle.
    assign w_advance    = !w_hold;
    assign i_item.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_score       <= i_item.score;
            r_query_index <= i_item.query_index;
            r_last_vector <= i_item.last_vector;
        end
    end

    // Items with an index beyond the active count leave no trace at all.
    assign w_in_range = (r_query_index <= r_last_idx);

    assign w_ctl.fire          = r_in_valid && w_advance && w_in_range;
    assign w_ctl.last_vector   = r_last_vector;
    assign w_ctl.end_of_vector = (r_query_index == r_last_idx);

    // The end of a vector decides whether the next vector opens a document:
    // only the end of a document's last vector does.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doc_start <= 1'b1;
        end else if (w_ctl.fire && w_ctl.end_of_vector) begin
            r_doc_start <= r_last_vector;
        end
    end

    smss_max_table #(
        .DEPTH (LIM),
        .IDX_W (IDX_W)
    ) u_max_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_index     (r_query_index[IDX_W-1:0]),
        .i_score     (r_score),
        .i_doc_start (r_doc_start),
        .o_max       (w_max)
    );

    smss_sum_unit u_sum_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_max    (w_max),
        .o_hold   (w_hold),
        .o_result (o_result)
    );

    // The stored last index never points past the table.
    a_last_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_idx <= smss_pkg::QIDX_W'(LIM - 1))
        else $error("last active query index beyond the table");

    // Ending a last vector always opens a new document.
    a_doc_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.fire && w_ctl.end_of_vector && w_ctl.last_vector) |=> r_doc_start)
        else $error("document start flag not set after a document end");

endmodule

/* dv/tb_segmented_maxsim_score.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segmented_maxsim_score: self-checking bench for the MaxSim document scorer
// Streams score items through the item channel with random gaps. A built-in
// predictor tracks the per-query maxima and the document sum. It checks every
// finished document score, in order, against what the predictor expects.
// ----------------------------------------------------------------------------
module tb_segmented_maxsim_score;

    // Cycles with no transfer on either channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last expected score. This covers an ignored or
    // non-scoring item that may still sit in the input register.
    localparam int SETTLE_CYCLES  = 6;
    localparam int STIM_ITEMS     = 1100;
    localparam int DIRECTED_ROWS  = 22;
    localparam int PHASES_FIXED   = 9;

    typedef logic signed [smss_pkg::SCORE_W-1:0] t_score;
    typedef logic signed [smss_pkg::SUM_W-1:0]   t_sum;
    typedef logic signed [smss_pkg::SUM_W:0]     t_wide;
    typedef logic [smss_pkg::QIDX_W-1:0]         t_qidx;

    // Kinds of disturbance mixed into otherwise well-formed documents.
    typedef enum logic [2:0] {
        CLEAN,
        STRAY_INDEX,   // index at or beyond the active count, must be ignored
        REPEAT_INDEX,  // same index sent twice in a row
        SKIP_INDEX,    // index left out of the vector
        WILD_ITEM      // any index, any last_vector flag
    } t_glitch;

    // One row of the directed table. When has_doc is set, the row's transfer
    // must produce exactly the doc_score given here.
    typedef struct packed {
        t_score      score;
        t_qidx       qidx;
        logic        last;
        logic [5:0]  reps;
        logic        has_doc;
        t_sum        doc;
    } t_dir_row;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [smss_pkg::CFG_W-1:0] cfg_wdata;

    smss_in_if  item_if ();
    smss_out_if res_if ();

    segmented_maxsim_score i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_if.sink),
        .o_result    (res_if.source)
    );

    // Predictor state: mirrors the register and the block's document state.
    logic [smss_pkg::CFG_W-1:0] active_cfg;
    t_score                     query_max_q [smss_pkg::QUERY_VECTORS_DEF];
    bit                         doc_first;
    t_sum                       doc_sum;

    // Document scores that the block still owes, oldest first.
    t_sum        doc_scores_due [$];
    int unsigned errors = 0;
    int unsigned scored_items;
    int unsigned idle_cycles = 0;
    bit          src_calm;
    bit          snk_calm = 1'b0;

    // The active count is clamped to 1 .. 32; zero behaves as one.
    function automatic int unsigned live_queries();
        if (active_cfg == 0) begin
            return 1;
        end
        if (active_cfg > smss_pkg::QUERY_VECTORS_DEF) begin
            return smss_pkg::QUERY_VECTORS_DEF;
        end
        return 32'(active_cfg);
    endfunction

    // Advances the predictor by one accepted item. Returns 1 when the item
    // finishes a document, with that document's saturated sum in doc.
    function automatic bit maxsim_step(input t_score s, input t_qidx q, input logic last,
                                       output t_sum doc);
        int unsigned n;
        t_score m;
        t_wide wide;
        n = live_queries();
        doc = '0;
        if (q >= n) begin
            return 0;
        end
        // The first vector of a document restarts the maximum from the score.
        m = (doc_first || s > query_max_q[q]) ? s : query_max_q[q];
        query_max_q[q] = m;
        if (last) begin
            wide = t_wide'(doc_sum) + t_wide'(m);
            if (wide > t_wide'(smss_pkg::SUM_MAX)) begin
                doc = smss_pkg::SUM_MAX;
            end else if (wide < t_wide'(smss_pkg::SUM_MIN)) begin
                doc = smss_pkg::SUM_MIN;
            end else begin
                doc = wide[smss_pkg::SUM_W-1:0];
            end
            if (q == n - 1) begin
                doc_sum = '0;
                doc_first = 1'b1;
                return 1;
            end
            doc_sum = doc;
            return 0;
        end
        if (q == n - 1) begin
            doc_first = 1'b0;
        end
        return 0;
    endfunction

    function automatic t_score pick_score();
        bit [31:0] raw;
        raw = $urandom();
        unique case ($urandom_range(0, 7))
            0: begin
                return 16'sh7FFF;
            end
            1: begin
                return 16'sh8000;
            end
            2: begin
                return '0;
            end
            3: begin
                return 16'shFFFF;
            end
            default: begin
                return raw[smss_pkg::SCORE_W-1:0];
            end
        endcase
    endfunction

    function automatic t_glitch pick_glitch();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            return STRAY_INDEX;
        end
        if (roll < 5) begin
            return REPEAT_INDEX;
        end
        if (roll < 7) begin
            return SKIP_INDEX;
        end
        if (roll < 8) begin
            return WILD_ITEM;
        end
        return CLEAN;
    endfunction

    // Offers one score item after a random gap and waits for its transfer.
    // The predictor runs at the transfer; a typed expectation, when given,
    // replaces the predicted value in the queue.
    task automatic send_score(input t_score s, input t_qidx q, input logic last,
                              input bit has_doc, input t_sum typed_doc);
        int unsigned gap;
        t_sum doc;
        if ($urandom_range(0, 39) == 0) begin
            src_calm = !src_calm;
        end
        gap = src_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid       <= 1'b1;
        item_if.score       <= s;
        item_if.query_index <= q;
        item_if.last_vector <= last;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        if (q < live_queries()) begin
            scored_items++;
        end
        if (maxsim_step(s, q, last, doc)) begin
            doc_scores_due.push_back(has_doc ? typed_doc : doc);
        end
    endtask

    // Lets the block go idle: every owed score has arrived and any trailing
    // item has had time to leave the pipeline.
    task automatic drain();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (doc_scores_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_active(input logic [smss_pkg::CFG_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        active_cfg = value;
    endtask

    // One document of 1 to 4 doc vectors, indices in order, with occasional
    // stray, repeated, skipped or arbitrary items mixed in.
    task automatic send_document(input int unsigned n);
        int unsigned vecs;
        int unsigned v;
        int unsigned q;
        logic last;
        t_qidx stray;
        t_glitch g;
        vecs = $urandom_range(1, 4);
        for (v = 0; v < vecs; v++) begin
            last = (v == vecs - 1);
            for (q = 0; q < n; q++) begin
                g = pick_glitch();
                unique case (g)
                    STRAY_INDEX: begin
                        if (n < smss_pkg::QUERY_VECTORS_DEF) begin
                            stray = t_qidx'($urandom_range(n,
                                                           smss_pkg::QUERY_VECTORS_DEF - 1));
                            send_score(pick_score(), stray, 1'($urandom_range(0, 1)),
                                       1'b0, '0);
                        end
                    end
                    REPEAT_INDEX: begin
                        send_score(pick_score(), t_qidx'(q), last, 1'b0, '0);
                    end
                    WILD_ITEM: begin
                        stray = t_qidx'($urandom_range(0, smss_pkg::QUERY_VECTORS_DEF - 1));
                        send_score(pick_score(), stray, 1'($urandom_range(0, 1)),
                                   1'b0, '0);
                    end
                    default: begin
                    end
                endcase
                if (g != SKIP_INDEX) begin
                    send_score(pick_score(), t_qidx'(q), last, 1'b0, '0);
                end
            end
        end
    endtask

    // Directed rows, walked with the active count set to 2. They cover both
    // score extremes, indices beyond the count, a multi-vector document, a
    // repeated index on a last vector, an index skipped on a first vector,
    // and the accumulator saturating high and low.
    t_dir_row directed [DIRECTED_ROWS] = '{
        '{16'sh7FFF,  5'd0,  1'b1, 6'd1,  1'b0, '0},
        '{16'sh7FFF,  5'd1,  1'b1, 6'd1,  1'b1, 21'sd65534},
        '{16'sh8000,  5'd0,  1'b1, 6'd1,  1'b0, '0},
        '{16'sh8000,  5'd1,  1'b1, 6'd1,  1'b1, -21'sd65536},
        '{16'sd1234,  5'd5,  1'b1, 6'd1,  1'b0, '0},
        '{16'shFFFF,  5'd31, 1'b0, 6'd1,  1'b0, '0},
        '{16'sd10,    5'd0,  1'b0, 6'd1,  1'b0, '0},
        '{16'sd20,    5'd1,  1'b0, 6'd1,  1'b0, '0},
        '{16'sd5,     5'd0,  1'b0, 6'd1,  1'b0, '0},
        '{16'sd30,    5'd1,  1'b0, 6'd1,  1'b0, '0},
        '{16'sd7,     5'd0,  1'b1, 6'd1,  1'b0, '0},
        '{16'sd1,     5'd1,  1'b1, 6'd1,  1'b0, '0},
        '{16'sd3,     5'd0,  1'b1, 6'd1,  1'b0, '0},
        '{16'sd4,     5'd0,  1'b1, 6'd1,  1'b0, '0},
        '{16'sd5,     5'd1,  1'b1, 6'd1,  1'b0, '0},
        '{16'sd50,    5'd1,  1'b0, 6'd1,  1'b0, '0},
        '{-16'sd5,    5'd0,  1'b1, 6'd1,  1'b0, '0},
        '{16'sd2,     5'd1,  1'b1, 6'd1,  1'b0, '0},
        '{16'sh7FFF,  5'd0,  1'b1, 6'd33, 1'b0, '0},
        '{16'sh7FFF,  5'd1,  1'b1, 6'd1,  1'b1, smss_pkg::SUM_MAX},
        '{16'sh8000,  5'd0,  1'b1, 6'd33, 1'b0, '0},
        '{16'sh8000,  5'd1,  1'b1, 6'd1,  1'b1, smss_pkg::SUM_MIN}
    };

    // Register settings for the first random phases: the smallest count, zero,
    // the largest register value, the reset value, just above the clamp, and
    // a few in between. Later phases draw the value at random.
    logic [smss_pkg::CFG_W-1:0] phase_cfg [PHASES_FIXED] = '{6'd1, 6'd0, 6'd63, 6'd32,
                                                             6'd3, 6'd33, 6'd7, 6'd31,
                                                             6'd16};

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: draws a stall before each transfer, checks every document
    // score against the oldest one owed.
    initial begin : result_sink
        int unsigned stall;
        t_sum want;
        res_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                snk_calm = !snk_calm;
            end
            stall = snk_calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
            if (doc_scores_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected doc_score, expected none, actual %0d",
                         $time, res_if.doc_score);
            end else begin
                want = doc_scores_due.pop_front();
                if (res_if.doc_score !== want) begin
                    errors++;
                    $display("%0t: doc_score mismatch, expected %0d, actual %0d",
                             $time, want, res_if.doc_score);
                end
            end
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned row;
        int unsigned phase;
        int unsigned n;
        int unsigned docs;
        int unsigned d;
        logic [smss_pkg::CFG_W-1:0] value;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        item_if.valid       <= 1'b0;
        item_if.score       <= '0;
        item_if.query_index <= '0;
        item_if.last_vector <= 1'b0;
        scored_items  = 0;
        src_calm      = 1'b0;

        // Predictor starts from the block's reset state.
        active_cfg = smss_pkg::CFG_W'(smss_pkg::ACTIVE_RESET);
        for (row = 0; row < smss_pkg::QUERY_VECTORS_DEF; row++) begin
            query_max_q[row] = '0;
        end
        doc_first = 1'b1;
        doc_sum   = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_active(6'd2);
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            repeat (directed[row].reps) begin
                send_score(directed[row].score, directed[row].qidx, directed[row].last,
                           directed[row].has_doc, directed[row].doc);
            end
        end

        // Random phases: one register setting each, then a batch of documents.
        // Wide counts get fewer documents so that scores keep arriving. The
        // stream stops at the first document boundary past the item budget.
        phase = 0;
        while (scored_items < STIM_ITEMS) begin
            value = (phase < PHASES_FIXED) ? phase_cfg[phase] :
                    smss_pkg::CFG_W'($urandom_range(0, 63));
            set_active(value);
            n = live_queries();
            docs = (n > 16) ? $urandom_range(2, 3) : $urandom_range(4, 12);
            for (d = 0; d < docs && scored_items < STIM_ITEMS; d++) begin
                send_document(n);
            end
            phase++;
        end

        drain();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* segmented_maxsim_score.f */
design/smss_pkg.sv
design/smss_in_if.sv
design/smss_out_if.sv
design/smss_max_table.sv
design/smss_sum_unit.sv
design/segmented_maxsim_score.sv
dv/tb_segmented_maxsim_score.sv
